// ===== sv/plrg_pkg.sv =====
// shared types and constants for the point-to-line residual and gradient block
// no dependencies
package plrg_pkg;

  // latency of the split multiplier and of the quotient pipeline
  localparam int MUL_LAT = 2;
  localparam int DIV_LAT = 33;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_DEGEN = 2'd1,
    ST_SAT   = 2'd2
  } status_t;

  // one result beat
  typedef struct packed {
    logic [31:0] grad_x;
    logic [31:0] grad_y;
    logic [31:0] grad_z;
    logic [31:0] dist_sq;
    status_t     status;
  } res_t;

endpackage

// ===== sv/plrg_dly.sv =====
// enabled delay line of fixed depth, used for valid and side data
// no dependencies
module plrg_dly #(
  parameter int W = 8,
  parameter int N = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  logic [W-1:0] pipe [N];

  // shift on every enabled cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < N; i++) pipe[i] <= '0;
    end else if (en) begin
      pipe[0] <= din;
      for (int i = 1; i < N; i++) pipe[i] <= pipe[i-1];
    end
  end

  assign dout = pipe[N-1];

endmodule

// ===== sv/plrg_mul.sv =====
// two-stage signed multiplier built from four partial products
// operands wider than 32 bits are split at bit 32; depends on nothing
module plrg_mul #(
  parameter int AW = 33,
  parameter int BW = 33
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [AW-1:0] a,
  input  logic signed [BW-1:0] b,
  output logic signed [AW+BW-1:0] p
);

  localparam int PW = AW + BW;

  logic signed [32:0]      al, bl;
  logic signed [AW-33:0]   ah;
  logic signed [BW-33:0]   bh;
  logic signed [65:0]      ll;
  logic signed [BW:0]      lh;
  logic signed [AW:0]      hl;
  logic signed [PW-65:0]   hh;

  // low halves as unsigned, high halves carry the sign
  assign al = $signed({1'b0, a[31:0]});
  assign bl = $signed({1'b0, b[31:0]});
  assign ah = $signed(a[AW-1:32]);
  assign bh = $signed(b[BW-1:32]);

  // partial products
  always_ff @(posedge clk) begin
    if (en) begin
      ll <= al * bl;
      lh <= al * bh;
      hl <= ah * bl;
      hh <= ah * bh;
    end
  end

  // recombine
  always_ff @(posedge clk) begin
    if (en) begin
      p <= PW'(ll) + (PW'(lh) << 32) + (PW'(hl) << 32) + (PW'(hh) << 64);
    end
  end

endmodule

// ===== sv/plrg_div.sv =====
// pipelined restoring divider, one quotient bit per stage, 32-bit quotient
// flags quotients of 2^32 or more; depends on nothing
module plrg_div #(
  parameter int NW = 102,
  parameter int DW = 66
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [31:0]   quo,
  output logic          big
);

  localparam int CW = DW + 32;
  localparam int MW = (NW > CW) ? NW : CW;

  logic [CW-1:0] rem   [33];
  logic [DW-1:0] den_r [33];
  logic [31:0]   q_r   [33];
  logic          big_r [33];
  logic          big_c;

  // overflow check against den shifted by the quotient width
  assign big_c = MW'(num) >= (MW'(den) << 32);

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]   <= CW'(num);
      den_r[0] <= den;
      q_r[0]   <= '0;
      big_r[0] <= big_c;
    end
  end

  // one compare and subtract per stage
  for (genvar i = 0; i < 32; i++) begin : g_step
    logic [CW-1:0] sh;
    logic          ge;
    assign sh = CW'(den_r[i]) << (31 - i);
    assign ge = rem[i] >= sh;
    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1]   <= ge ? rem[i] - sh : rem[i];
        den_r[i+1] <= den_r[i];
        q_r[i+1]   <= q_r[i] | (32'(ge) << (31 - i));
        big_r[i+1] <= big_r[i];
      end
    end
  end

  assign quo = q_r[32];
  assign big = big_r[32];

endmodule

// ===== sv/point_line_residual_gradient_top.sv =====
// point-to-line squared distance and gradient row, fully pipelined
// one beat per cycle sustained while out_ready stays high; a full skid register stalls the pipeline
// latency is set by the 33-stage quotient pipeline, two split multipliers and four registers
// an output skid register catches a result that arrives while another waits; input is then held until it drains
// synchronous reset clears valid bits and the delay lines; no state beyond the pipeline
// depends on plrg_pkg, plrg_dly, plrg_mul, plrg_div
module point_line_residual_gradient_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic signed [31:0] point_z,
  input  logic signed [31:0] line_a_x,
  input  logic signed [31:0] line_a_y,
  input  logic signed [31:0] line_a_z,
  input  logic signed [31:0] line_b_x,
  input  logic signed [31:0] line_b_y,
  input  logic signed [31:0] line_b_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] grad_x,
  output logic signed [31:0] grad_y,
  output logic signed [31:0] grad_z,
  output logic        [31:0] dist_sq,
  output logic        [1:0]  result_status
);
  import plrg_pkg::*;

  localparam int TOT_LAT = 1 + MUL_LAT + 1 + MUL_LAT + 1 + DIV_LAT;

  logic en;
  logic signed [31:0] pt [3];
  logic signed [31:0] la [3];
  logic signed [31:0] lb [3];

  assign pt[0] = point_x;  assign pt[1] = point_y;  assign pt[2] = point_z;
  assign la[0] = line_a_x; assign la[1] = line_a_y; assign la[2] = line_a_z;
  assign lb[0] = line_b_x; assign lb[1] = line_b_y; assign lb[2] = line_b_z;

  // stage a: line direction and offset of the point
  logic signed [32:0] d_a [3];
  logic signed [32:0] v_a [3];
  logic               val_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      val_a <= 1'b0;
    end else if (en) begin
      val_a <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        d_a[i] <= $signed({lb[i][31], lb[i]}) - $signed({la[i][31], la[i]});
        v_a[i] <= $signed({pt[i][31], pt[i]}) - $signed({la[i][31], la[i]});
      end
    end
  end

  // first products: |d|^2 terms and cross product terms
  logic signed [65:0] ddp [3];
  logic signed [65:0] wpa [3];
  logic signed [65:0] wpb [3];

  for (genvar i = 0; i < 3; i++) begin : g_m1
    localparam int J = (i + 1) % 3;
    localparam int K = (i + 2) % 3;
    plrg_mul #(.AW(33), .BW(33)) u_dd (
      .clk(clk), .en(en), .a(d_a[i]), .b(d_a[i]), .p(ddp[i])
    );
    plrg_mul #(.AW(33), .BW(33)) u_wa (
      .clk(clk), .en(en), .a(d_a[J]), .b(v_a[K]), .p(wpa[i])
    );
    plrg_mul #(.AW(33), .BW(33)) u_wb (
      .clk(clk), .en(en), .a(d_a[K]), .b(v_a[J]), .p(wpb[i])
    );
  end

  // stage d: w = d x v and |d|^2
  logic signed [66:0] w_d [3];
  logic        [65:0] dd_d;
  logic signed [67:0] dd_sum;

  assign dd_sum = 68'(ddp[0]) + 68'(ddp[1]) + 68'(ddp[2]);

  always_ff @(posedge clk) begin
    if (en) begin
      dd_d <= dd_sum[65:0];
      for (int i = 0; i < 3; i++) w_d[i] <= 67'(wpa[i]) - 67'(wpb[i]);
    end
  end

  // direction delayed to line up with w
  logic [98:0]        d_pk;
  logic signed [32:0] d_d [3];

  plrg_dly #(.W(99), .N(1 + MUL_LAT)) u_d_dly (
    .clk(clk), .rst(rst), .en(en),
    .din({d_a[2], d_a[1], d_a[0]}), .dout(d_pk)
  );
  assign d_d[0] = $signed(d_pk[32:0]);
  assign d_d[1] = $signed(d_pk[65:33]);
  assign d_d[2] = $signed(d_pk[98:66]);

  // second products: w x d terms and |w|^2 terms
  logic signed [99:0]  gpa [3];
  logic signed [99:0]  gpb [3];
  logic signed [133:0] wwp [3];

  for (genvar i = 0; i < 3; i++) begin : g_m2
    localparam int J = (i + 1) % 3;
    localparam int K = (i + 2) % 3;
    plrg_mul #(.AW(67), .BW(33)) u_ga (
      .clk(clk), .en(en), .a(w_d[J]), .b(d_d[K]), .p(gpa[i])
    );
    plrg_mul #(.AW(67), .BW(33)) u_gb (
      .clk(clk), .en(en), .a(w_d[K]), .b(d_d[J]), .p(gpb[i])
    );
    plrg_mul #(.AW(67), .BW(67)) u_ww (
      .clk(clk), .en(en), .a(w_d[i]), .b(w_d[i]), .p(wwp[i])
    );
  end

  // stage g: magnitude and sign of 2*(w x d), and |w|^2
  logic        [101:0] gmag_g [3];
  logic        [2:0]   gneg_g;
  logic        [133:0] ww_g;
  logic signed [135:0] ww_sum;
  logic        [65:0]  dd_g;

  assign ww_sum = 136'(wwp[0]) + 136'(wwp[1]) + 136'(wwp[2]);

  always_ff @(posedge clk) begin
    if (en) begin
      ww_g <= ww_sum[133:0];
      for (int i = 0; i < 3; i++) begin
        logic signed [101:0] g2;
        g2 = {(101'(gpa[i]) - 101'(gpb[i])), 1'b0};
        gneg_g[i] <= g2[101];
        gmag_g[i] <= g2[101] ? 102'(-g2) : 102'(g2);
      end
    end
  end

  plrg_dly #(.W(66), .N(1 + MUL_LAT)) u_dd_dly (
    .clk(clk), .rst(rst), .en(en), .din(dd_d), .dout(dd_g)
  );

  // quotients
  logic [31:0] gq [3];
  logic [2:0]  gb;
  logic [31:0] dq;
  logic        db;

  for (genvar i = 0; i < 3; i++) begin : g_div
    plrg_div #(.NW(102), .DW(66)) u_gdiv (
      .clk(clk), .en(en), .num(gmag_g[i]), .den(dd_g), .quo(gq[i]), .big(gb[i])
    );
  end

  plrg_div #(.NW(134), .DW(82)) u_ddiv (
    .clk(clk), .en(en), .num(ww_g), .den({dd_g, 16'b0}), .quo(dq), .big(db)
  );

  // sign and degenerate flag alongside the divider
  logic [3:0] side_q;
  logic       val_q;

  plrg_dly #(.W(4), .N(DIV_LAT)) u_side_dly (
    .clk(clk), .rst(rst), .en(en),
    .din({(dd_g == 66'd0), gneg_g}), .dout(side_q)
  );

  plrg_dly #(.W(1), .N(TOT_LAT - 1)) u_val_dly (
    .clk(clk), .rst(rst), .en(en), .din(val_a), .dout(val_q)
  );

  // saturation and status
  res_t        res_c;
  logic [31:0] gv [3];
  logic        sat;

  always_comb begin
    sat = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (side_q[i]) begin
        if (gb[i] || gq[i] > 32'h8000_0000) begin
          gv[i] = 32'h8000_0000;
          sat   = 1'b1;
        end else begin
          gv[i] = -gq[i];
        end
      end else begin
        if (gb[i] || gq[i][31]) begin
          gv[i] = 32'h7FFF_FFFF;
          sat   = 1'b1;
        end else begin
          gv[i] = gq[i];
        end
      end
    end
    res_c.grad_x  = gv[0];
    res_c.grad_y  = gv[1];
    res_c.grad_z  = gv[2];
    res_c.dist_sq = db ? 32'hFFFF_FFFF : dq;
    if (db) sat = 1'b1;
    res_c.status  = sat ? ST_SAT : ST_OK;
    if (side_q[3]) begin
      res_c.grad_x  = '0;
      res_c.grad_y  = '0;
      res_c.grad_z  = '0;
      res_c.dist_sq = '0;
      res_c.status  = ST_DEGEN;
    end
  end

  // output register with skid beat
  res_t out_r;
  res_t skid_r;
  logic skid_v;
  logic push;

  assign en   = !skid_v;
  assign push = en && val_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_v    <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_v) begin
        out_valid <= 1'b1;
        skid_v    <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      out_r <= skid_v ? skid_r : res_c;
    end else if (push) begin
      skid_r <= res_c;
    end
  end

  assign in_ready      = en;
  assign grad_x        = $signed(out_r.grad_x);
  assign grad_y        = $signed(out_r.grad_y);
  assign grad_z        = $signed(out_r.grad_z);
  assign dist_sq       = out_r.dist_sq;
  assign result_status = out_r.status;

endmodule

// ===== bench/tb.sv =====
// self-checking bench for point_line_residual_gradient_top
// predicts each beat with wide exact integer arithmetic; depends on plrg_pkg
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import plrg_pkg::*;

  localparam int N_RAND = 700;
  localparam int CYC_LIMIT = 400000;

  typedef struct packed {
    logic [31:0] gx;
    logic [31:0] gy;
    logic [31:0] gz;
    logic [31:0] dsq;
    status_t     st;
  } expect_t;

  typedef logic signed [31:0] coord_t;
  typedef struct {
    coord_t c[9];
  } beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  coord_t point_x = '0, point_y = '0, point_z = '0;
  coord_t line_a_x = '0, line_a_y = '0, line_a_z = '0;
  coord_t line_b_x = '0, line_b_y = '0, line_b_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] grad_x, grad_y, grad_z;
  logic [31:0] dist_sq;
  logic [1:0] result_status;

  expect_t pending_results[$];
  int errors = 0;
  int n_sent = 0;
  int n_recv = 0;
  int n_degen = 0;
  int n_sat = 0;
  int cycles = 0;
  bit hold_off = 0;
  bit no_idle = 0;

  point_line_residual_gradient_top uut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .point_x(point_x), .point_y(point_y), .point_z(point_z),
    .line_a_x(line_a_x), .line_a_y(line_a_y), .line_a_z(line_a_z),
    .line_b_x(line_b_x), .line_b_y(line_b_y), .line_b_z(line_b_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .grad_x(grad_x), .grad_y(grad_y), .grad_z(grad_z),
    .dist_sq(dist_sq), .result_status(result_status)
  );

  always #10 clk = ~clk;

  // signed quotient truncated toward zero, clamped to 32 bits
  function automatic logic [31:0] clamp_grad(input logic signed [159:0] num,
                                             input logic signed [159:0] den,
                                             inout bit sat);
    logic signed [159:0] q;
    begin
      q = num / den;
      if (q > 160'sd2147483647) begin
        sat = 1;
        return 32'h7fffffff;
      end
      if (q < -160'sd2147483648) begin
        sat = 1;
        return 32'h80000000;
      end
      return q[31:0];
    end
  endfunction

  // exact residual and gradient of one beat
  function automatic expect_t line_residual(input beat_t b);
    logic signed [159:0] d[3], v[3], w[3], g[3], dd, ww, q;
    expect_t r;
    bit sat;
    begin
      sat = 0;
      for (int i = 0; i < 3; i++) begin
        d[i] = 160'(b.c[6+i]) - 160'(b.c[3+i]);
        v[i] = 160'(b.c[i]) - 160'(b.c[3+i]);
      end
      dd = d[0]*d[0] + d[1]*d[1] + d[2]*d[2];
      if (dd == 0) begin
        r = '{gx: '0, gy: '0, gz: '0, dsq: '0, st: ST_DEGEN};
        return r;
      end
      w[0] = d[1]*v[2] - d[2]*v[1];
      w[1] = d[2]*v[0] - d[0]*v[2];
      w[2] = d[0]*v[1] - d[1]*v[0];
      g[0] = w[1]*d[2] - w[2]*d[1];
      g[1] = w[2]*d[0] - w[0]*d[2];
      g[2] = w[0]*d[1] - w[1]*d[0];
      r.gx = clamp_grad(2*g[0], dd, sat);
      r.gy = clamp_grad(2*g[1], dd, sat);
      r.gz = clamp_grad(2*g[2], dd, sat);
      ww = w[0]*w[0] + w[1]*w[1] + w[2]*w[2];
      q = ww / (dd <<< 16);
      if (q > 160'sd4294967295) begin
        sat = 1;
        r.dsq = 32'hffffffff;
      end else begin
        r.dsq = q[31:0];
      end
      r.st = sat ? ST_SAT : ST_OK;
      return r;
    end
  endfunction

  // random coordinate: half small, some full range, sometimes near the extremes
  function automatic coord_t rand_coord();
    int sel;
    begin
      sel = $urandom_range(0, 9);
      if (sel < 5) return coord_t'($urandom_range(0, 32'h3ffff)) - 32'sh20000;
      if (sel < 8) return coord_t'($urandom);
      if (sel == 8) return 32'sh7fffffff - coord_t'($urandom_range(0, 3));
      return 32'sh80000000 + coord_t'($urandom_range(0, 3));
    end
  endfunction

  // offer one beat and wait for it to be taken; valid drops only while idling
  task automatic send_beat(input beat_t b);
    begin
      while (!no_idle && $urandom_range(0, 99) < 26) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      point_x <= b.c[0]; point_y <= b.c[1]; point_z <= b.c[2];
      line_a_x <= b.c[3]; line_a_y <= b.c[4]; line_a_z <= b.c[5];
      line_b_x <= b.c[6]; line_b_y <= b.c[7]; line_b_z <= b.c[8];
      in_valid <= 1'b1;
      @(posedge clk);
      while (!in_ready) @(posedge clk);
      pending_results = {pending_results, line_residual(b)};
      n_sent++;
    end
  endtask

  // receiver: random stalls, one long hold-off, no idling while no_idle is set
  always @(posedge clk) begin
    if (rst || hold_off) out_ready <= 1'b0;
    else out_ready <= no_idle || ($urandom_range(0, 99) >= 26);
  end

  // result checking on accepted beats
  always @(posedge clk) begin
    expect_t e;
    if (!rst && out_valid && out_ready) begin
      n_recv++;
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (grad_x !== e.gx) begin
          $error("grad_x expected %h got %h", e.gx, grad_x); errors++;
        end
        if (grad_y !== e.gy) begin
          $error("grad_y expected %h got %h", e.gy, grad_y); errors++;
        end
        if (grad_z !== e.gz) begin
          $error("grad_z expected %h got %h", e.gz, grad_z); errors++;
        end
        if (dist_sq !== e.dsq) begin
          $error("dist_sq expected %h got %h", e.dsq, dist_sq); errors++;
        end
        if (result_status !== e.st) begin
          $error("result_status expected %0d got %0d", e.st, result_status); errors++;
        end
        if (e.st == ST_DEGEN) n_degen++;
        if (e.st == ST_SAT) n_sat++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYC_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // long receiver hold-off so the pipeline fills and stalls its input
  initial begin
    wait (n_sent == 100);
    hold_off = 1;
    repeat (150) @(posedge clk);
    hold_off = 0;
  end

  // directed rows: point, line a, line b; some with typed-in results
  localparam int N_DIR = 12;
  coord_t dir_tab[N_DIR][9] = '{
    '{0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{32'sh7fffffff, 32'sh80000000, 5, 32'sh7fffffff, 32'sh7fffffff,
      32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff},
    '{32'sh80000000, 32'sh80000000, 32'sh80000000, 0, 0, 0, 32'sh10000, 0, 0},
    '{0, 32'sh10000, 0, 0, 0, 0, 32'sh10000, 0, 0},
    '{0, 32'sh7fffffff, 32'sh7fffffff, 0, 0, 0, 1, 0, 0},
    '{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000,
      32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff},
    '{32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh80000000,
      32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff},
    '{32'sh30000, 32'sh20000, 32'sh10000, 0, 0, 0, 32'sh10000, 32'sh10000, 32'sh10000},
    '{5, 32'shffff0000, 7, 32'sh10000, 32'sh10000, 0, 32'sh10000, 32'sh10000, 0},
    '{32'shffffffff, 32'shffffffff, 32'shffffffff, 1, 1, 1, 2, 2, 2},
    '{32'sh12345678, 32'shedcba987, 32'sh55555555, 32'shaaaaaaaa, 0, 32'sh55555555,
      32'sh2aaaaaaa, 32'sh12340000, 32'sh80000000},
    '{0, 0, 32'sh7fffffff, 32'sh80000000, 0, 0, 32'sh7fffffff, 0, 0}
  };

  initial begin
    beat_t b;
    expect_t e;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int r = 0; r < N_DIR; r++) begin
      for (int k = 0; k < 9; k++) b.c[k] = dir_tab[r][k];
      e = line_residual(b);
      // degenerate rows have known results
      if (r < 2 && e != expect_t'{gx: '0, gy: '0, gz: '0, dsq: '0, st: ST_DEGEN}) begin
        $error("degenerate row %0d predicted wrongly", r); errors++;
      end
      send_beat(b);
    end

    for (int n = 0; n < N_RAND; n++) begin
      no_idle = (n >= 300 && n < 400);
      for (int k = 0; k < 9; k++) b.c[k] = rand_coord();
      // some zero-length lines, and some with line b's x close to line a's x
      case ($urandom_range(0, 9))
        0: for (int k = 0; k < 3; k++) b.c[6+k] = b.c[3+k];
        1: b.c[6] = b.c[3] + coord_t'($urandom_range(0, 3));
        default: ;
      endcase
      send_beat(b);
    end
    in_valid <= 1'b0;
    no_idle = 0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("covered %0d beats: %0d degenerate, %0d saturated", n_recv, n_degen, n_sat);
    $display("directed extremes, zero-length lines, long output stall included");
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule

// ===== point_line_residual_gradient_top.f =====
sv/plrg_pkg.sv
sv/plrg_dly.sv
sv/plrg_mul.sv
sv/plrg_div.sv
sv/point_line_residual_gradient_top.sv
bench/tb.sv
